/* design/abkf_pkg.sv */
`default_nettype none
package abkf_pkg;

  localparam int AXES_DEFAULT = 2;
  localparam int CFG_W = 28;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [3:0] OP_LOAD = 4'd0;
  localparam logic [3:0] OP_PRED_ANG = 4'd1;
  localparam logic [3:0] OP_T = 4'd2;
  localparam logic [3:0] OP_P00 = 4'd3;
  localparam logic [3:0] OP_P11 = 4'd4;
  localparam logic [3:0] OP_DIV0 = 4'd5;
  localparam logic [3:0] OP_DIV1 = 4'd6;
  localparam logic [3:0] OP_CORR_ANG = 4'd7;
  localparam logic [3:0] OP_CORR_BIA = 4'd8;
  localparam logic [3:0] OP_CP00 = 4'd9;
  localparam logic [3:0] OP_CP01 = 4'd10;
  localparam logic [3:0] OP_CP10 = 4'd11;
  localparam logic [3:0] OP_CP11 = 4'd12;
  localparam logic [3:0] OP_STORE = 4'd13;
  localparam logic [3:0] OP_NONE = 4'd14;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_pos;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [71:0] rsh(input logic signed [71:0] v,
                                              input int n);
    logic signed [71:0] u;
    u = v + (72'sd1 <<< (n - 1));
    return u >>> n;
  endfunction

endpackage
`default_nettype wire

/* design/angle_bias_kalman_filter.sv */
// Two-state tilt filter: angle and gyro bias per axis.
// Input channel in_valid/in_ready carries axis, gyro_rate, measured_angle and
// time_step. Result channel out_valid/out_ready carries angle_out and bias_out.
// Configuration channel cfg_valid/cfg_ready writes cfg_index/cfg_data, and is
// always ready; write it only while the block is idle.
// One item is processed at a time. The processing time is set by the
// bit-serial divider, which computes each of the two gains in turn, and by a
// single shared multiplier stepped by the controller. When the innovation
// variance is not positive the gains are skipped, and the result is valid
// sooner.
// The result stays on the output until taken; a new item is accepted only
// after that. Reset clears all estimates and covariances to zero and loads
// the default noise registers.
`default_nettype none
module angle_bias_kalman_filter #(
  parameter int AXES = abkf_pkg::AXES_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [0:0]         axis,
  input  wire logic signed [24:0] gyro_rate,
  input  wire logic signed [24:0] measured_angle,
  input  wire logic [19:0]        time_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      angle_out,
  output logic signed [31:0]      bias_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  logic [27:0] angle_noise, bias_noise, measure_noise;
  abkf_pkg::cmd_t    cmd;
  abkf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= 28'd16777;
      bias_noise <= 28'd50332;
      measure_noise <= 28'd503316;
    end else if (cfg_valid) begin
      case (cfg_index)
        abkf_pkg::REG_ANGLE_NOISE: angle_noise <= cfg_data[27:0];
        abkf_pkg::REG_BIAS_NOISE: bias_noise <= cfg_data[27:0];
        abkf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_data[27:0];
        default: begin
        end
      endcase
    end
  end

  abkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  abkf_datapath #(.AXES(AXES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .axis(axis),
    .gyro_rate(gyro_rate), .measured_angle(measured_angle),
    .time_step(time_step), .angle_noise(angle_noise), .bias_noise(bias_noise),
    .measure_noise(measure_noise), .angle_out(angle_out), .bias_out(bias_out)
  );
endmodule
`default_nettype wire

/* design/abkf_div.sv */
`default_nettype none
module abkf_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [55:0]        dividend,
  input  wire logic [32:0]        divisor,
  output logic                    done,
  output logic [55:0]             quotient
);
  logic [55:0] q;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem[32:0], q[55]} - {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        q <= dividend;
        rem <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          q <= {q[54:0], 1'b1};
        end else begin
          rem <= {rem[32:0], q[55]};
          q <= {q[54:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd55) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* design/abkf_datapath.sv */
`default_nettype none
module abkf_datapath #(
  parameter int AXES = abkf_pkg::AXES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire abkf_pkg::cmd_t      cmd,
  output abkf_pkg::status_t        status,
  input  wire logic [0:0]          axis,
  input  wire logic signed [24:0]  gyro_rate,
  input  wire logic signed [24:0]  measured_angle,
  input  wire logic [19:0]         time_step,
  input  wire logic [27:0]         angle_noise,
  input  wire logic [27:0]         bias_noise,
  input  wire logic [27:0]         measure_noise,
  output logic signed [31:0]       angle_out,
  output logic signed [31:0]       bias_out
);
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic signed [31:0] ang_mem [AXES];
  logic signed [31:0] bia_mem [AXES];
  logic signed [31:0] p_mem [4*AXES];
  logic [AXES-1:0]    vld;

  logic [AW-1:0] ax;
  logic [AW-1:0] ax_in;
  logic signed [31:0] ang, bia, p00, p01, p10, p11, t, k0, k1, y;
  logic signed [24:0] meas;
  logic signed [25:0] rate;
  logic signed [20:0] dt;

  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;
  logic signed [71:0] pw;

  logic               div_start, div_done;
  logic [55:0]        div_dend, div_q;
  logic [32:0]        s_val;
  logic               div_neg;
  logic signed [71:0] qs;
  logic signed [33:0] s_full;

  assign ax_in = (AXES > 1) ? AW'(axis) : '0;

  assign s_full = 34'(p00) + $signed({6'd0, measure_noise});
  assign status.s_pos = (s_full > 34'sd0);
  assign status.done = div_done;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      abkf_pkg::OP_PRED_ANG: begin ma = 34'(rate) - 34'(bia); mb = 34'(dt); end
      abkf_pkg::OP_T:        begin ma = 34'(p11); mb = 34'(dt); end
      abkf_pkg::OP_P00: begin
        ma = 34'(t) - 34'(p01) - 34'(p10) + $signed({6'd0, angle_noise});
        mb = 34'(dt);
      end
      abkf_pkg::OP_P11:      begin ma = $signed({6'd0, bias_noise}); mb = 34'(dt); end
      abkf_pkg::OP_CORR_ANG: begin ma = 34'(k0); mb = 34'(y); end
      abkf_pkg::OP_CORR_BIA: begin ma = 34'(k1); mb = 34'(y); end
      abkf_pkg::OP_CP00:     begin ma = 34'(k0); mb = 34'(p00); end
      abkf_pkg::OP_CP01:     begin ma = 34'(k0); mb = 34'(p01); end
      abkf_pkg::OP_CP10:     begin ma = 34'(k1); mb = 34'(p00); end
      abkf_pkg::OP_CP11:     begin ma = 34'(k1); mb = 34'(p01); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;
  assign pw = 72'(prod);
  assign qs = div_neg ? -$signed({16'd0, div_q}) : $signed({16'd0, div_q});

  abkf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dend),
    .divisor(s_val), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_dend = '0;
    div_neg = 1'b0;
    if (cmd.op == abkf_pkg::OP_DIV0) begin
      div_neg = p00[31];
      div_dend = {p00[31] ? 32'(-33'(p00)) : 32'(p00), 24'd0};
    end else if (cmd.op == abkf_pkg::OP_DIV1) begin
      div_neg = p10[31];
      div_dend = {p10[31] ? 32'(-33'(p10)) : 32'(p10), 24'd0};
    end
    div_start = cmd.start;
  end

  assign angle_out = ang;
  assign bias_out = bia;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      case (cmd.op)
        abkf_pkg::OP_LOAD: begin
          ax <= ax_in;
          rate <= 26'(gyro_rate);
          meas <= measured_angle;
          dt <= $signed({1'b0, time_step});
          ang <= vld[ax_in] ? ang_mem[ax_in] : '0;
          bia <= vld[ax_in] ? bia_mem[ax_in] : '0;
          p00 <= vld[ax_in] ? p_mem[{ax_in, 2'd0}] : '0;
          p01 <= vld[ax_in] ? p_mem[{ax_in, 2'd1}] : '0;
          p10 <= vld[ax_in] ? p_mem[{ax_in, 2'd2}] : '0;
          p11 <= vld[ax_in] ? p_mem[{ax_in, 2'd3}] : '0;
        end
        abkf_pkg::OP_PRED_ANG: ang <= abkf_pkg::sat32(72'(ang) + abkf_pkg::rsh(pw, 20));
        abkf_pkg::OP_T: t <= 32'(abkf_pkg::rsh(pw, 20));
        abkf_pkg::OP_P00: begin
          p00 <= abkf_pkg::sat32(72'(p00) + abkf_pkg::rsh(pw, 20));
          p01 <= abkf_pkg::sat32(72'(p01) - 72'(t));
          p10 <= abkf_pkg::sat32(72'(p10) - 72'(t));
        end
        abkf_pkg::OP_P11: begin
          p11 <= abkf_pkg::sat32(72'(p11) + abkf_pkg::rsh(pw, 20));
        end
        abkf_pkg::OP_DIV0: begin
          s_val <= s_full[32:0];
          if (div_done) k0 <= abkf_pkg::sat32(qs);
        end
        abkf_pkg::OP_DIV1: begin
          if (div_done) begin
            k1 <= abkf_pkg::sat32(qs);
            y <= abkf_pkg::sat32(72'(meas) - 72'(ang));
          end
        end
        abkf_pkg::OP_CORR_ANG: ang <= abkf_pkg::sat32(72'(ang) + abkf_pkg::rsh(pw, 24));
        abkf_pkg::OP_CORR_BIA: bia <= abkf_pkg::sat32(72'(bia) + abkf_pkg::rsh(pw, 24));
        abkf_pkg::OP_CP00: t <= abkf_pkg::sat32(72'(p00) - abkf_pkg::rsh(pw, 24));
        abkf_pkg::OP_CP01: y <= abkf_pkg::sat32(72'(p01) - abkf_pkg::rsh(pw, 24));
        abkf_pkg::OP_CP10: p10 <= abkf_pkg::sat32(72'(p10) - abkf_pkg::rsh(pw, 24));
        abkf_pkg::OP_CP11: begin
          p11 <= abkf_pkg::sat32(72'(p11) - abkf_pkg::rsh(pw, 24));
          p00 <= t;
          p01 <= y;
        end
        abkf_pkg::OP_STORE: begin
          vld[ax] <= 1'b1;
          ang_mem[ax] <= ang;
          bia_mem[ax] <= bia;
          p_mem[{ax, 2'd0}] <= p00;
          p_mem[{ax, 2'd1}] <= p01;
          p_mem[{ax, 2'd2}] <= p10;
          p_mem[{ax, 2'd3}] <= p11;
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/abkf_ctrl.sv */
`default_nettype none
module abkf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output abkf_pkg::cmd_t         cmd,
  input  wire abkf_pkg::status_t status
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  logic [3:0] op;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.start = 1'b0;
    cmd.op = abkf_pkg::OP_NONE;
    if (state == S_IDLE && in_valid) begin
      cmd.op = abkf_pkg::OP_LOAD;
    end else if (state == S_RUN) begin
      cmd.op = op;
      cmd.start = (op == abkf_pkg::OP_DIV0 || op == abkf_pkg::OP_DIV1);
    end else if (state == S_WAIT) begin
      cmd.op = op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= abkf_pkg::OP_PRED_ANG;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_RUN;
          op <= abkf_pkg::OP_PRED_ANG;
        end
        S_RUN: begin
          if (op == abkf_pkg::OP_DIV0) begin
            state <= status.s_pos ? S_WAIT : S_RUN;
            if (!status.s_pos) op <= abkf_pkg::OP_STORE;
          end else if (op == abkf_pkg::OP_DIV1) begin
            state <= S_WAIT;
          end else if (op == abkf_pkg::OP_STORE) begin
            state <= S_OUT;
          end else begin
            op <= op + 4'd1;
          end
        end
        S_WAIT: if (status.done) begin
          state <= S_RUN;
          op <= op + 4'd1;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RUN) else $error("item not started");
endmodule
`default_nettype wire

/* verif/angle_bias_kalman_filter_checker.sv */
`timescale 1ns / 1ps
module angle_bias_kalman_filter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [0:0]         axis,
  input  logic signed [24:0] gyro_rate,
  input  logic signed [24:0] measured_angle,
  input  logic [19:0]        time_step,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] angle_out,
  input  logic signed [31:0] bias_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 pending,
  output int                 fail_count
);
  localparam int NUM_AXES = 2;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  estimate_t estimates_due[$];
  longint angle_noise_q, bias_noise_q, measure_noise_q;
  longint angle_est [NUM_AXES];
  longint bias_est [NUM_AXES];
  longint cov [4*NUM_AXES];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic filter_step(input int ax, input longint rate, input longint meas,
                             input longint dt);
    longint ang, bia, p00, p01, p10, p11, t, s, k0, k1, y;
    estimate_t e;
    ang = angle_est[ax];
    bia = bias_est[ax];
    ang = clamp32(ang + round_shift((rate - bia) * dt, 20));
    p00 = cov[4*ax]; p01 = cov[4*ax+1]; p10 = cov[4*ax+2]; p11 = cov[4*ax+3];
    t = round_shift(dt * p11, 20);
    p00 = clamp32(p00 + round_shift(dt * (t - p01 - p10 + angle_noise_q), 20));
    p01 = clamp32(p01 - t);
    p10 = clamp32(p10 - t);
    p11 = clamp32(p11 + round_shift(bias_noise_q * dt, 20));
    s = p00 + measure_noise_q;
    if (s > 0) begin
      k0 = clamp32((p00 * 64'sd16777216) / s);
      k1 = clamp32((p10 * 64'sd16777216) / s);
      y = clamp32(meas - ang);
      ang = clamp32(ang + round_shift(k0 * y, 24));
      bia = clamp32(bia + round_shift(k1 * y, 24));
      t = p00;
      s = p01;
      p00 = clamp32(p00 - round_shift(k0 * t, 24));
      p01 = clamp32(p01 - round_shift(k0 * s, 24));
      p10 = clamp32(p10 - round_shift(k1 * t, 24));
      p11 = clamp32(p11 - round_shift(k1 * s, 24));
    end
    cov[4*ax] = p00; cov[4*ax+1] = p01; cov[4*ax+2] = p10; cov[4*ax+3] = p11;
    angle_est[ax] = ang;
    bias_est[ax] = bia;
    e.angle = ang[31:0];
    e.bias = bia[31:0];
    estimates_due.push_back(e);
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    estimate_t e;
    if (rst) begin
      angle_noise_q = 16777;
      bias_noise_q = 50332;
      measure_noise_q = 503316;
      foreach (angle_est[i]) angle_est[i] = 0;
      foreach (bias_est[i]) bias_est[i] = 0;
      foreach (cov[i]) cov[i] = 0;
      estimates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          abkf_pkg::REG_ANGLE_NOISE: angle_noise_q = longint'(cfg_data[27:0]);
          abkf_pkg::REG_BIAS_NOISE: bias_noise_q = longint'(cfg_data[27:0]);
          abkf_pkg::REG_MEASURE_NOISE: measure_noise_q = longint'(cfg_data[27:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (estimates_due.size() == 0) begin
          $display("unexpected item angle %0d bias %0d at %0t", angle_out, bias_out, $time);
          fail_count++;
        end else begin
          e = estimates_due.pop_front();
          if (angle_out !== e.angle) report("angle_out", angle_out, e.angle);
          if (bias_out !== e.bias) report("bias_out", bias_out, e.bias);
        end
      end
      if (in_valid && in_ready) begin
        filter_step(int'(axis) % NUM_AXES, longint'(gyro_rate), longint'(measured_angle),
                    longint'(time_step));
      end
    end
    pending = estimates_due.size();
  end
endmodule

/* verif/angle_bias_kalman_filter_test.sv */
`timescale 1ns / 1ps
module angle_bias_kalman_filter_test;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int RATE_MAX = 16777215;
  localparam int RATE_MIN = -16777216;
  localparam int ANGLE_LIM = 11796480;
  localparam int DT_MAX = 1048575;
  localparam logic [27:0] NOISE_MAX = 28'hfffffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] axis = '0;
  logic signed [24:0] gyro_rate = '0;
  logic signed [24:0] measured_angle = '0;
  logic [19:0] time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] angle_out;
  logic signed [31:0] bias_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int pending;
  int fail_count;
  bit steady = 1'b0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  angle_bias_kalman_filter u_dut (.*);

  angle_bias_kalman_filter_checker u_checker (.*);

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= gap_length();
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [0:0] ax, input int rate, input int meas,
                           input int dt);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    axis <= ax;
    gyro_rate <= rate[24:0];
    measured_angle <= meas[24:0];
    time_step <= dt[19:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int dt;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DT_MAX) : $urandom_range(0, 4000);
      send_item($urandom_range(0, 1), $urandom_range(0, 33554431) - 16777216,
                $urandom_range(0, 2 * ANGLE_LIM) - ANGLE_LIM, dt);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [27:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= {4'($urandom_range(0, 15)), value};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_noise(input logic [27:0] a, input logic [27:0] b,
                             input logic [27:0] m);
    write_reg(abkf_pkg::REG_ANGLE_NOISE, a);
    write_reg(abkf_pkg::REG_BIAS_NOISE, b);
    write_reg(abkf_pkg::REG_MEASURE_NOISE, m);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(0, 0, 0, 0);
    send_item(1, 0, 0, 0);
    send_item(0, RATE_MAX, ANGLE_LIM, DT_MAX);
    send_item(1, RATE_MIN, -ANGLE_LIM, DT_MAX);
    send_item(0, RATE_MAX, -ANGLE_LIM, DT_MAX);
    send_item(1, RATE_MIN, ANGLE_LIM, 1);
    send_item(0, RATE_MAX, ANGLE_LIM, DT_MAX);
    send_item(0, RATE_MAX, ANGLE_LIM, DT_MAX);
    send_item(1, -1, -1, 1049);
    send_item(1, 65536, 65536, 1049);
    send_item(0, 0, ANGLE_LIM, 0);
    send_item(1, RATE_MIN, 0, DT_MAX);
    send_item(0, 12345, -54321, 1000);
    wait_idle();

    write_noise(28'd0, 28'd0, 28'd1);
    write_reg(REG_SPARE, NOISE_MAX);
    send_item(0, RATE_MAX, ANGLE_LIM, DT_MAX);
    send_item(1, RATE_MIN, -ANGLE_LIM, DT_MAX);
    send_item(0, 0, -ANGLE_LIM, 0);
    send_item(1, 0, ANGLE_LIM, 0);
    send_random(150);
    wait_idle();

    write_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX);
    send_item(0, RATE_MAX, ANGLE_LIM, DT_MAX);
    send_item(1, RATE_MIN, -ANGLE_LIM, DT_MAX);
    send_random(150);
    wait_idle();

    write_noise(28'd16777, 28'd50332, 28'd503316);
    send_random(400);
    wait_idle();

    write_noise($urandom_range(0, 28'hfffffff), $urandom_range(0, 28'hfffffff),
                $urandom_range(1, 28'hfffffff));
    send_random(400);
    wait_idle();

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
